// ----- rtl/ipv4rx_pkg.sv -----
`timescale 1ns / 1ps

package ipv4rx_pkg;

    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned SUM_W        = 20;
    localparam int unsigned IDX_W        = $clog2(HEADER_BYTES);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // header byte positions
    localparam logic [IDX_W-1:0] IDX_PROTOCOL    = IDX_W'(9);
    localparam logic [IDX_W-1:0] IDX_CHECKSUM_LO = IDX_W'(11);
    localparam logic [IDX_W-1:0] IDX_SRC_FIRST   = IDX_W'(12);
    localparam logic [IDX_W-1:0] IDX_SRC_LAST    = IDX_W'(15);
    localparam logic [IDX_W-1:0] IDX_DST_FIRST   = IDX_W'(16);
    localparam logic [IDX_W-1:0] IDX_DST_LAST    = IDX_W'(19);

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [2:0] VERDICT_TOO_SHORT    = 3'd0;
    localparam logic [2:0] VERDICT_BAD_CHECKSUM = 3'd1;
    localparam logic [2:0] VERDICT_NOT_FOR_US   = 3'd2;
    localparam logic [2:0] VERDICT_ICMP         = 3'd3;
    localparam logic [2:0] VERDICT_TCP          = 3'd4;
    localparam logic [2:0] VERDICT_UDP          = 3'd5;
    localparam logic [2:0] VERDICT_OTHER        = 3'd6;

    // register map
    localparam int unsigned PADDR_W      = 3;
    localparam logic        REG_LOCAL_IP = 1'b0;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] source_ip;
        logic [7:0]  protocol;
        logic [15:0] payload_length;
    } out_t;

endpackage

// ----- rtl/ipv4rx_parse.sv -----
`timescale 1ns / 1ps

module ipv4rx_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  ipv4rx_pkg::in_t   item,
    input  logic [31:0]       local_ip,
    output ipv4rx_pkg::out_t  result
);

    logic [ipv4rx_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ipv4rx_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [7:0]                     high_reg, high_next;
    logic [15:0]                    csum_reg, csum_next;
    logic [7:0]                     proto_reg, proto_next;
    logic [31:0]                    src_reg, src_next;
    logic [31:0]                    dst_reg, dst_next;

    logic [ipv4rx_pkg::IDX_W-1:0]   idx;
    logic                           in_header;
    logic [15:0]                    word;
    logic [16:0]                    fold1;
    logic [15:0]                    fold2;
    logic [15:0]                    calc_csum;
    logic                           short_pkt;

    assign idx       = count_reg[ipv4rx_pkg::IDX_W-1:0];
    assign in_header = count_reg < ipv4rx_pkg::COUNT_W'(ipv4rx_pkg::HEADER_BYTES);
    assign word      = {high_reg, item.packet_byte};

    always_comb
    begin
        sum_next   = sum_reg;
        high_next  = high_reg;
        csum_next  = csum_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        if (in_header)
        begin
            if (!idx[0])
            begin
                high_next = item.packet_byte;
            end
            else if (idx == ipv4rx_pkg::IDX_CHECKSUM_LO)
            begin
                csum_next = word;
            end
            else
            begin
                sum_next = sum_reg + ipv4rx_pkg::SUM_W'(word);
            end
            if (idx == ipv4rx_pkg::IDX_PROTOCOL)
            begin
                proto_next = item.packet_byte;
            end
            if (idx >= ipv4rx_pkg::IDX_SRC_FIRST && idx <= ipv4rx_pkg::IDX_SRC_LAST)
            begin
                src_next = {src_reg[23:0], item.packet_byte};
            end
            if (idx >= ipv4rx_pkg::IDX_DST_FIRST && idx <= ipv4rx_pkg::IDX_DST_LAST)
            begin
                dst_next = {dst_reg[23:0], item.packet_byte};
            end
        end
        count_next = (count_reg == ipv4rx_pkg::COUNT_MAX) ? count_reg
                                                           : count_reg + 1'b1;
    end

    // end-around fold of the header sum
    assign fold1     = {1'b0, sum_next[15:0]}
                     + 17'(sum_next[ipv4rx_pkg::SUM_W-1:16]);
    assign fold2     = fold1[15:0] + 16'(fold1[16]);
    assign calc_csum = ~fold2;
    assign short_pkt = count_next < ipv4rx_pkg::COUNT_W'(ipv4rx_pkg::HEADER_BYTES);

    always_comb
    begin
        result = '0;
        if (short_pkt)
        begin
            result.verdict = ipv4rx_pkg::VERDICT_TOO_SHORT;
        end
        else
        begin
            result.source_ip      = src_next;
            result.protocol       = proto_next;
            result.payload_length = count_next
                                  - ipv4rx_pkg::COUNT_W'(ipv4rx_pkg::HEADER_BYTES);
            if (calc_csum != csum_next)
            begin
                result.verdict = ipv4rx_pkg::VERDICT_BAD_CHECKSUM;
            end
            else if (dst_next != local_ip)
            begin
                result.verdict = ipv4rx_pkg::VERDICT_NOT_FOR_US;
            end
            else if (proto_next == ipv4rx_pkg::PROTO_ICMP)
            begin
                result.verdict = ipv4rx_pkg::VERDICT_ICMP;
            end
            else if (proto_next == ipv4rx_pkg::PROTO_TCP)
            begin
                result.verdict = ipv4rx_pkg::VERDICT_TCP;
            end
            else if (proto_next == ipv4rx_pkg::PROTO_UDP)
            begin
                result.verdict = ipv4rx_pkg::VERDICT_UDP;
            end
            else
            begin
                result.verdict = ipv4rx_pkg::VERDICT_OTHER;
            end
        end
    end

    // per-packet state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            high_reg  <= '0;
            csum_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                high_reg  <= '0;
                csum_reg  <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                high_reg  <= high_next;
                csum_reg  <= csum_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
            end
        end
    end

endmodule

// ----- rtl/ipv4_receive_header_checker_core.sv -----
`timescale 1ns / 1ps

// ipv4 receive header checker
// in channel: one packet byte per request on in_data, last_byte marks the
//   final byte of a packet; bytes are taken with in_valid and in_ready
// out channel: one result per packet on out_data (verdict, source address,
//   protocol, payload length), handed over with out_valid and out_ready
// apb port: register local_ip at address 0, to be written by the user only while no packet
//   is in flight (the block itself does not enforce this); pready is always high
// a final byte accepted into the input register gives its result on out_data once it moves
//   on through the parse logic into the output register, when the output is free
// throughput: one byte per cycle while no final byte waits on a stalled output; the sum, the
//   field capture and the verdict are all settled between the input and the output register
// a stalled receiver holds the result in the output register; further bytes
//   of the next packet keep flowing until its final byte reaches the input
//   register, which then waits for the output to drain
// reset clears local_ip, the byte counter, the sum and all held fields

module ipv4_receive_header_checker_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ipv4rx_pkg::in_t                    in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ipv4rx_pkg::out_t                   out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ipv4rx_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic              in_valid_reg, in_valid_next;
    ipv4rx_pkg::in_t   in_reg;
    logic              out_valid_reg, out_valid_next;
    ipv4rx_pkg::out_t  out_reg;
    logic [31:0]       local_ip_reg;
    logic              advance;
    logic              reg_sel;
    ipv4rx_pkg::out_t  result;

    assign advance  = in_valid_reg && (!in_reg.last_byte || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && in_reg.last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (advance && in_reg.last_byte)
        begin
            out_reg <= result;
        end
    end

    ipv4rx_parse u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (advance),
        .item     (in_reg),
        .local_ip (local_ip_reg),
        .result   (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // apb register
    assign reg_sel = paddr[2] == ipv4rx_pkg::REG_LOCAL_IP;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? local_ip_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            local_ip_reg <= pwdata;
        end
    end

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.last_byte |=> out_valid_reg)
        else $error("final byte left no result");

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("waiting byte lost from input register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && in_valid_reg && in_reg.last_byte |-> !in_ready)
        else $error("input taken while result is blocked");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.verdict == ipv4rx_pkg::VERDICT_TOO_SHORT
        |-> out_reg.source_ip == '0 && out_reg.protocol == '0
            && out_reg.payload_length == '0)
        else $error("short packet result carries fields");

endmodule

// ----- test/tb_ipv4_receive_header_checker_core.sv -----
`timescale 1ns / 1ps

module tb_ipv4_receive_header_checker_core;

    localparam int unsigned QUIET_LIMIT     = 5000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned PHASE_BYTES     = 400;

    logic                               clk;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    ipv4rx_pkg::in_t                    in_data   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    ipv4rx_pkg::out_t                   out_data;
    logic                               psel      = 1'b0;
    logic                               penable   = 1'b0;
    logic                               pwrite    = 1'b0;
    logic [ipv4rx_pkg::PADDR_W-1:0]     paddr     = '0;
    logic [31:0]                        pwdata    = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    ipv4_receive_header_checker_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // requests waiting to be offered, and verdicts waiting to come out
    ipv4rx_pkg::in_t  request_queue[$];
    ipv4rx_pkg::out_t pending_verdicts[$];

    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_trigger   = 0;
    int unsigned error_count    = 0;
    int unsigned bytes_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned verdict_seen[7];

    // predictor state, kept per packet
    logic [31:0]                        local_ip_copy = '0;
    logic [ipv4rx_pkg::COUNT_W-1:0]     pkt_count     = '0;
    logic [ipv4rx_pkg::SUM_W-1:0]       hdr_sum       = '0;
    logic [7:0]                         hi_hold       = '0;
    logic [15:0]                        rx_checksum   = '0;
    logic [7:0]                         proto_hold    = '0;
    logic [31:0]                        src_hold      = '0;
    logic [31:0]                        dst_hold      = '0;

    function automatic logic [15:0] ones_complement_checksum(
        input logic [ipv4rx_pkg::SUM_W-1:0] sum);
        logic [16:0] folded;
        folded = 17'(sum[15:0]) + 17'(sum[ipv4rx_pkg::SUM_W-1:16]);
        folded = 17'(folded[15:0]) + 17'(folded[16]);
        return ~folded[15:0];
    endfunction

    function automatic void clear_packet_state();
        pkt_count   = '0;
        hdr_sum     = '0;
        hi_hold     = '0;
        rx_checksum = '0;
        proto_hold  = '0;
        src_hold    = '0;
        dst_hold    = '0;
    endfunction

    function automatic bit predict_verdict(input ipv4rx_pkg::in_t req,
                                           output ipv4rx_pkg::out_t res);
        logic [15:0] word;
        word = {hi_hold, req.packet_byte};
        res  = '0;
        if (pkt_count < ipv4rx_pkg::HEADER_BYTES)
        begin
            if (!pkt_count[0])
                hi_hold = req.packet_byte;
            else if (pkt_count == ipv4rx_pkg::IDX_CHECKSUM_LO)
                rx_checksum = word;
            else
                hdr_sum = hdr_sum + ipv4rx_pkg::SUM_W'(word);
            if (pkt_count == ipv4rx_pkg::IDX_PROTOCOL)
                proto_hold = req.packet_byte;
            if (pkt_count >= ipv4rx_pkg::IDX_SRC_FIRST && pkt_count <= ipv4rx_pkg::IDX_SRC_LAST)
                src_hold = {src_hold[23:0], req.packet_byte};
            if (pkt_count >= ipv4rx_pkg::IDX_DST_FIRST && pkt_count <= ipv4rx_pkg::IDX_DST_LAST)
                dst_hold = {dst_hold[23:0], req.packet_byte};
        end
        if (pkt_count != ipv4rx_pkg::COUNT_MAX)
            pkt_count = pkt_count + 1'b1;
        if (!req.last_byte)
            return 1'b0;
        if (pkt_count < ipv4rx_pkg::HEADER_BYTES)
            res.verdict = ipv4rx_pkg::VERDICT_TOO_SHORT;
        else
        begin
            if (ones_complement_checksum(hdr_sum) != rx_checksum)
                res.verdict = ipv4rx_pkg::VERDICT_BAD_CHECKSUM;
            else if (dst_hold != local_ip_copy)
                res.verdict = ipv4rx_pkg::VERDICT_NOT_FOR_US;
            else if (proto_hold == ipv4rx_pkg::PROTO_ICMP)
                res.verdict = ipv4rx_pkg::VERDICT_ICMP;
            else if (proto_hold == ipv4rx_pkg::PROTO_TCP)
                res.verdict = ipv4rx_pkg::VERDICT_TCP;
            else if (proto_hold == ipv4rx_pkg::PROTO_UDP)
                res.verdict = ipv4rx_pkg::VERDICT_UDP;
            else
                res.verdict = ipv4rx_pkg::VERDICT_OTHER;
            res.source_ip      = src_hold;
            res.protocol       = proto_hold;
            res.payload_length = pkt_count - 16'(ipv4rx_pkg::HEADER_BYTES);
        end
        clear_packet_state();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s after %0d results: got %0h, expected %0h",
                 field, results_checked, got, want);
        error_count++;
    endtask

    task automatic push_request(input logic [7:0] value, input logic last);
        ipv4rx_pkg::in_t req;
        req.packet_byte = value;
        req.last_byte   = last;
        request_queue.push_back(req);
    endtask

    task automatic queue_packet(input int unsigned len, input logic [31:0] dst,
                                input logic [7:0] proto, input bit fix_sum);
        logic [7:0]                   hdr [ipv4rx_pkg::HEADER_BYTES];
        logic [ipv4rx_pkg::SUM_W-1:0] acc;
        logic [15:0]                  sum_field;
        for (int i = 0; i < ipv4rx_pkg::HEADER_BYTES; i++)
            hdr[i] = 8'($urandom_range(255));
        hdr[ipv4rx_pkg::IDX_PROTOCOL] = proto;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
        if (fix_sum)
        begin
            acc = '0;
            for (int w = 0; w < ipv4rx_pkg::HEADER_BYTES / 2; w++)
                if (2 * w + 1 != ipv4rx_pkg::IDX_CHECKSUM_LO)
                    acc = acc + ipv4rx_pkg::SUM_W'({hdr[2 * w], hdr[2 * w + 1]});
            sum_field = ones_complement_checksum(acc);
            {hdr[10], hdr[11]} = sum_field;
        end
        for (int unsigned i = 0; i < len; i++)
            push_request((i < ipv4rx_pkg::HEADER_BYTES) ? hdr[i] : 8'($urandom_range(255)),
                         i == len - 1);
    endtask

    task automatic queue_random_packets(input int unsigned byte_target);
        int unsigned queued;
        int unsigned kind;
        int unsigned len;
        logic [31:0] dst;
        logic [7:0]  proto;
        queued = 0;
        while (queued < byte_target)
        begin
            kind = $urandom_range(99);
            if ($urandom_range(24) == 0)
                len = $urandom_range(ipv4rx_pkg::HEADER_BYTES, 300);
            else
                len = $urandom_range(ipv4rx_pkg::HEADER_BYTES, ipv4rx_pkg::HEADER_BYTES + 40);
            case ($urandom_range(3))
                0:       proto = ipv4rx_pkg::PROTO_ICMP;
                1:       proto = ipv4rx_pkg::PROTO_TCP;
                2:       proto = ipv4rx_pkg::PROTO_UDP;
                default: proto = 8'($urandom_range(255));
            endcase
            dst = local_ip_copy;
            if (kind < 8)
                len = $urandom_range(1, ipv4rx_pkg::HEADER_BYTES - 1);
            else if (kind < 16)
            begin
                dst = $urandom();
                if (dst == local_ip_copy)
                    dst = ~dst;
            end
            queue_packet(len, dst, proto, kind < 16 || kind >= 24);
            queued += len;
        end
    endtask

    task automatic write_local_ip(input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ipv4rx_pkg::PADDR_W'(4 * ipv4rx_pkg::REG_LOCAL_IP);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        local_ip_copy = value;
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || pending_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        ipv4rx_pkg::out_t predicted;
        bit               advance;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            advance = !in_valid;
            if (in_valid && in_ready)
            begin
                bytes_sent++;
                advance = 1'b1;
                if (predict_verdict(in_data, predicted))
                    pending_verdicts.push_back(predicted);
            end
            if (advance)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= request_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long hold-off on request, otherwise random stalls
    always @(posedge clk or negedge rst_n)
    begin : ready_driver
        int unsigned hold_seen;
        int unsigned hold_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        ipv4rx_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("result with nothing pending", 32'(out_data.verdict), 32'(0));
            else
            begin
                want = pending_verdicts.pop_front();
                results_checked++;
                verdict_seen[want.verdict]++;
                if (out_data.verdict !== want.verdict)
                    report_mismatch("verdict", 32'(out_data.verdict), 32'(want.verdict));
                if (out_data.source_ip !== want.source_ip)
                    report_mismatch("source_ip", out_data.source_ip, want.source_ip);
                if (out_data.protocol !== want.protocol)
                    report_mismatch("protocol", 32'(out_data.protocol), 32'(want.protocol));
                if (out_data.payload_length !== want.payload_length)
                    report_mismatch("payload_length", 32'(out_data.payload_length),
                                    32'(want.payload_length));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no progress for %0d cycles", QUIET_LIMIT);
            $display("** ipv4_receive_header_checker_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [31:0] phase_ip   [5];
        int unsigned phase_gap  [5];
        int unsigned phase_stall[5];
        phase_ip    = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), $urandom(), $urandom()};
        phase_gap   = '{0, 0, 72, 0, 20};
        phase_stall = '{0, 0, 0, 72, 20};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_local_ip($urandom());
        push_request(8'hFF, 1'b1);
        for (int i = 0; i < ipv4rx_pkg::HEADER_BYTES - 1; i++)
            push_request(8'h00, i == ipv4rx_pkg::HEADER_BYTES - 2);
        queue_packet(ipv4rx_pkg::HEADER_BYTES, local_ip_copy, ipv4rx_pkg::PROTO_ICMP, 1'b1);
        queue_packet(ipv4rx_pkg::HEADER_BYTES + 1, local_ip_copy, ipv4rx_pkg::PROTO_TCP, 1'b1);
        queue_packet(ipv4rx_pkg::HEADER_BYTES + 8, local_ip_copy, ipv4rx_pkg::PROTO_UDP, 1'b1);
        queue_packet(ipv4rx_pkg::HEADER_BYTES, local_ip_copy, 8'hFF, 1'b1);
        queue_packet(ipv4rx_pkg::HEADER_BYTES, local_ip_copy, 8'h00, 1'b1);
        queue_packet(ipv4rx_pkg::HEADER_BYTES, local_ip_copy, ipv4rx_pkg::PROTO_TCP, 1'b0);
        queue_packet(ipv4rx_pkg::HEADER_BYTES, ~local_ip_copy, ipv4rx_pkg::PROTO_UDP, 1'b1);
        wait_until_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_local_ip(phase_ip[phase]);
            send_idle_pct = phase_gap[phase];
            stall_pct     = phase_stall[phase];
            queue_random_packets(PHASE_BYTES);
            if (phase == 0)
                hold_trigger++;
            wait_until_drained();
        end

        $display("covered %0d bytes and %0d checked results under six local addresses,",
                 bytes_sent, results_checked);
        $display("verdicts: short %0d, bad sum %0d, not ours %0d, icmp %0d, tcp %0d, udp %0d, other %0d",
                 verdict_seen[ipv4rx_pkg::VERDICT_TOO_SHORT],
                 verdict_seen[ipv4rx_pkg::VERDICT_BAD_CHECKSUM],
                 verdict_seen[ipv4rx_pkg::VERDICT_NOT_FOR_US],
                 verdict_seen[ipv4rx_pkg::VERDICT_ICMP],
                 verdict_seen[ipv4rx_pkg::VERDICT_TCP],
                 verdict_seen[ipv4rx_pkg::VERDICT_UDP],
                 verdict_seen[ipv4rx_pkg::VERDICT_OTHER]);
        if (error_count == 0)
            $display("** ipv4_receive_header_checker_core: PASSED **");
        else
            $display("** ipv4_receive_header_checker_core: FAILED **");
        $finish;
    end

endmodule
